FILE: src/sti_pkg.sv
package sti_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ADC_BITS_DEF    = 10;

    localparam int DIA_W        = 15;
    localparam int DIAM_W       = 16;
    localparam int PWM_W        = 8;
    localparam int PNUM_W       = DIAM_W + 1 + PWM_W;
    localparam int ENTRY_IDX_W  = 4;
    localparam int CNT_CFG_W    = 5;
    localparam int SAT_W        = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 15;

    localparam logic [PWM_W-1:0] PWM_MAX = 8'd255;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_ADC     = 3'd4;

    localparam logic [CNT_CFG_W-1:0]  ENTRY_COUNT_RST = 5'd2;
    localparam logic [DIA_W-1:0]      PWM_LOW_RST     = 15'd0;
    localparam logic [DIA_W-1:0]      PWM_HIGH_RST    = 15'd3000;
    localparam logic [DIA_W-1:0]      FAULT_MIN_RST   = 15'd1500;
    localparam logic [SAT_W-1:0]      SAT_ADC_RST     = 10'd3;

    typedef struct packed {
        logic start;
        logic short_q;
    } div_ctl_t;

endpackage

FILE: src/sti_table.sv
module sti_table
    import sti_pkg::*;
#(
    parameter int DEPTH  = TABLE_DEPTH_DEF,
    parameter int AW     = 4,
    parameter int DATA_W = ADC_BITS_DEF + DIA_W
)(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/sti_divider.sv
module sti_divider
    import sti_pkg::*;
#(
    parameter int NW          = DIA_W + ADC_BITS_DEF,
    parameter int DW          = DIA_W,
    parameter int SHORT_STEPS = PWM_W
)(
    input  logic          clk,
    input  logic          rst_n,
    input  div_ctl_t      ctl,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);

    localparam int CNTW = $clog2(NW + 1);

    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   sh_reg;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DW:0] shifted;
    logic [DW:0] trial;
    logic        fits;

    assign shifted = {rem_reg, sh_reg[NW-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.short_q ? CNTW'(SHORT_STEPS) : CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // short mode: quotient known to fit SHORT_STEPS bits, skip leading steps
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            den_reg <= den;
            if (ctl.short_q)
            begin
                rem_reg <= DW'(num >> SHORT_STEPS);
                sh_reg  <= num << (NW - SHORT_STEPS);
            end
            else
            begin
                rem_reg <= '0;
                sh_reg  <= num;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DW-1:0] : shifted[DW-1:0];
            sh_reg  <= {sh_reg[NW-2:0], fits};
        end
    end

    assign quo  = sh_reg;
    assign done = done_reg;

endmodule

FILE: src/sensor_table_interpolator.sv
// Table write: done is strobed in the cycle after accept; busy stays low.
// Conversion: the table scan over at most n entries, n the clamped entry count,
// (one entry per cycle through the memory read port), then, where needed,
// the bit-serial divider (15 + ADC_BITS steps, then 8 steps for the PWM map).
// One item at a time; the next is taken in the cycle its predecessor's result shows.
// Reset clears config registers to defaults and the controller to idle; table undefined.
module sensor_table_interpolator
    import sti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADC_BITS    = ADC_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic                    req_type,
    input  logic [ENTRY_IDX_W-1:0]  entry_index,
    input  logic [ADC_BITS-1:0]     entry_adc,
    input  logic [DIA_W-1:0]        entry_dia_um,
    input  logic [ADC_BITS-1:0]     sample,
    output logic                    done,
    output logic signed [DIAM_W-1:0] diameter_um,
    output logic [PWM_W-1:0]        pwm_level,
    output logic                    fault,
    output logic                    out_of_range
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CWD  = $clog2(TABLE_DEPTH + 1);
    localparam int CW   = (CWD > CNT_CFG_W) ? CWD : CNT_CFG_W;
    localparam int EW   = ADC_BITS + DIA_W;
    localparam int NW   = DIA_W + ADC_BITS;
    localparam int DW   = (ADC_BITS > DIA_W) ? ADC_BITS : DIA_W;
    localparam int PW   = DIAM_W + ADC_BITS + 1;
    localparam int SW   = NW + 2;
    localparam int SCW  = (ADC_BITS > SAT_W) ? ADC_BITS : SAT_W;

    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);
    localparam logic [CW-1:0] TD_C  = CW'(TABLE_DEPTH);
    localparam logic signed [SW-1:0] SAT_MAX = SW'(32767);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(32768);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_DIV_I = 8'b0000_1000,
        ST_SUM   = 8'b0001_0000,
        ST_MAP   = 8'b0010_0000,
        ST_DIV_P = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_CFG_W-1:0] entry_count_reg;
    logic [DIA_W-1:0]     pwm_low_reg;
    logic [DIA_W-1:0]     pwm_high_reg;
    logic [DIA_W-1:0]     fault_min_reg;
    logic [SAT_W-1:0]     sat_adc_reg;

    logic [ADC_BITS-1:0]      sample_reg;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            addr_reg;
    logic [ADC_BITS-1:0]      prev_adc_reg;
    logic [DIA_W-1:0]         prev_dia_reg;
    logic [ADC_BITS-1:0]      cur_adc_reg;
    logic [DIA_W-1:0]         cur_dia_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [ADC_BITS:0] den_reg;
    logic signed [NW:0]       q_reg;
    logic signed [DIAM_W-1:0] dia_reg;
    logic                     oor_reg;
    logic [PWM_W-1:0]         pwm_reg;
    logic [NW-1:0]            pnum_reg;
    logic [DW-1:0]            span_reg;
    logic                     div_start_reg;

    logic                     done_reg;
    logic signed [DIAM_W-1:0] res_dia_reg;
    logic [PWM_W-1:0]         res_pwm_reg;
    logic                     res_fault_reg;
    logic                     res_oor_reg;

    logic              accept;
    logic              tbl_we;
    logic [CW-1:0]     widx_ext;
    logic [AW-1:0]     tbl_raddr;
    logic [EW-1:0]     tbl_rdata;
    logic [ADC_BITS-1:0] rd_adc;
    logic [DIA_W-1:0]  rd_dia;
    logic [CW-1:0]     ec_ext;
    logic [CW-1:0]     n_clamp;
    logic              found;
    logic              first_beat;
    logic              last_beat;

    logic signed [DIAM_W-1:0]  dd;
    logic signed [ADC_BITS:0]  ds;
    logic signed [ADC_BITS:0]  den_w;
    logic                      den_zero;
    logic signed [PW-1:0]      prod_abs;
    logic signed [ADC_BITS:0]  den_abs;
    logic                      q_neg;
    logic signed [SW-1:0]      sum_w;
    logic signed [DIAM_W-1:0]  dia_sat;
    logic signed [DIAM_W-1:0]  span_w;
    logic signed [DIAM_W:0]    diff_w;
    logic signed [PNUM_W-1:0]  pn_w;
    logic                      map_zero;
    logic                      map_full;
    logic                      map_div;
    logic                      fault_w;

    div_ctl_t       div_ctl;
    logic [NW-1:0]  div_num;
    logic [DW-1:0]  div_den;
    logic [NW-1:0]  div_quo;
    logic           div_done;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
            pwm_low_reg     <= PWM_LOW_RST;
            pwm_high_reg    <= PWM_HIGH_RST;
            fault_min_reg   <= FAULT_MIN_RST;
            sat_adc_reg     <= SAT_ADC_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[CNT_CFG_W-1:0];
                REG_PWM_LOW:     pwm_low_reg     <= cfg_data[DIA_W-1:0];
                REG_PWM_HIGH:    pwm_high_reg    <= cfg_data[DIA_W-1:0];
                REG_FAULT_MIN:   fault_min_reg   <= cfg_data[DIA_W-1:0];
                REG_SAT_ADC:     sat_adc_reg     <= cfg_data[SAT_W-1:0];
                default:         ;
            endcase
        end
    end

    // table
    assign widx_ext  = CW'(entry_index);
    assign tbl_we    = accept && (req_type == REQ_WRITE) && (widx_ext < TD_C);
    assign tbl_raddr = (state_reg == ST_SCAN) ? addr_reg[AW-1:0] : '0;

    sti_table #(
        .DEPTH  (TABLE_DEPTH),
        .AW     (AW),
        .DATA_W (EW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (widx_ext[AW-1:0]),
        .wdata ({entry_adc, entry_dia_um}),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign rd_adc = tbl_rdata[EW-1:DIA_W];
    assign rd_dia = tbl_rdata[DIA_W-1:0];

    assign ec_ext  = CW'(entry_count_reg);
    assign n_clamp = (ec_ext < TWO_C) ? TWO_C : ((ec_ext > TD_C) ? TD_C : ec_ext);

    // rd data holds entry addr_reg - 1 during scan
    assign found      = rd_adc > sample_reg;
    assign first_beat = (addr_reg == ONE_C);
    assign last_beat  = (addr_reg == n_reg);

    assign dd       = $signed({1'b0, cur_dia_reg}) - $signed({1'b0, prev_dia_reg});
    assign ds       = $signed({1'b0, sample_reg}) - $signed({1'b0, prev_adc_reg});
    assign den_w    = $signed({1'b0, cur_adc_reg}) - $signed({1'b0, prev_adc_reg});
    assign den_zero = (cur_adc_reg == prev_adc_reg);

    assign prod_abs = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign den_abs  = den_reg[ADC_BITS] ? -den_reg : den_reg;
    assign q_neg    = prod_reg[PW-1] ^ den_reg[ADC_BITS];

    assign sum_w   = SW'($signed({1'b0, prev_dia_reg})) + SW'(q_reg);
    assign dia_sat = (sum_w > SAT_MAX) ? DIAM_W'(SAT_MAX) :
                     ((sum_w < SAT_MIN) ? DIAM_W'(SAT_MIN) : sum_w[DIAM_W-1:0]);

    assign span_w   = $signed({1'b0, pwm_high_reg}) - $signed({1'b0, pwm_low_reg});
    assign diff_w   = $signed({dia_reg[DIAM_W-1], dia_reg}) - $signed({2'b00, pwm_low_reg});
    assign pn_w     = (PNUM_W'(diff_w) <<< PWM_W) - PNUM_W'(diff_w);
    assign map_zero = (span_w <= 0) || (diff_w <= 0);
    assign map_full = diff_w >= $signed({span_w[DIAM_W-1], span_w});
    assign map_div  = !map_zero && !map_full;

    assign fault_w = (SCW'(sample_reg) < SCW'(sat_adc_reg)) ||
                     (dia_reg < $signed({1'b0, fault_min_reg}));

    // divider
    assign div_ctl.start   = div_start_reg;
    assign div_ctl.short_q = (state_reg == ST_DIV_P);
    assign div_num = (state_reg == ST_DIV_P) ? pnum_reg : prod_abs[NW-1:0];
    assign div_den = (state_reg == ST_DIV_P) ? span_reg : DW'(den_abs[ADC_BITS-1:0]);

    sti_divider #(
        .NW          (NW),
        .DW          (DW),
        .SHORT_STEPS (PWM_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_CONVERT))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!first_beat)
                begin
                    if (found)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (last_beat)
                    begin
                        state_next = ST_MAP;
                    end
                end
            end
            ST_MUL:   state_next = den_zero ? ST_SUM : ST_DIV_I;
            ST_DIV_I: state_next = div_done ? ST_SUM : ST_DIV_I;
            ST_SUM:   state_next = ST_MAP;
            ST_MAP:   state_next = map_div ? ST_DIV_P : ST_FIN;
            ST_DIV_P: state_next = div_done ? ST_FIN : ST_DIV_P;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= (accept && (req_type == REQ_WRITE)) || (state_reg == ST_FIN);
            div_start_reg <= ((state_reg == ST_MUL) && !den_zero) ||
                             ((state_reg == ST_MAP) && map_div);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= sample;
                n_reg      <= n_clamp;
                addr_reg   <= ONE_C;
                if (accept && (req_type == REQ_WRITE))
                begin
                    res_dia_reg   <= '0;
                    res_pwm_reg   <= '0;
                    res_fault_reg <= 1'b0;
                    res_oor_reg   <= 1'b0;
                end
            end
            ST_SCAN:
            begin
                addr_reg <= addr_reg + ONE_C;
                if (first_beat || !found)
                begin
                    prev_adc_reg <= rd_adc;
                    prev_dia_reg <= rd_dia;
                end
                else
                begin
                    cur_adc_reg <= rd_adc;
                    cur_dia_reg <= rd_dia;
                end
                oor_reg <= !first_beat && !found && last_beat;
                if (!first_beat && !found && last_beat)
                begin
                    dia_reg <= $signed({1'b0, rd_dia});
                end
            end
            ST_MUL:
            begin
                prod_reg <= PW'(dd) * PW'(ds);
                den_reg  <= den_w;
                q_reg    <= '0;
            end
            ST_DIV_I:
            begin
                if (div_done)
                begin
                    q_reg <= q_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                end
            end
            ST_SUM:
            begin
                dia_reg <= dia_sat;
            end
            ST_MAP:
            begin
                pwm_reg  <= map_zero ? '0 : PWM_MAX;
                pnum_reg <= NW'(pn_w[PNUM_W-2:0]);
                span_reg <= DW'(span_w[DIA_W-1:0]);
            end
            ST_DIV_P:
            begin
                if (div_done)
                begin
                    pwm_reg <= div_quo[PWM_W-1:0];
                end
            end
            ST_FIN:
            begin
                res_dia_reg   <= dia_reg;
                res_pwm_reg   <= pwm_reg;
                res_fault_reg <= fault_w;
                res_oor_reg   <= oor_reg;
            end
            default: ;
        endcase
    end

    assign done         = done_reg;
    assign diameter_um  = res_dia_reg;
    assign pwm_level    = res_pwm_reg;
    assign fault        = res_fault_reg;
    assign out_of_range = res_oor_reg;

endmodule

FILE: src/sti_checker.sv
module sti_checker
    import sti_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     req_type,
    input logic                     done,
    input logic signed [DIAM_W-1:0] diameter_um,
    input logic [PWM_W-1:0]         pwm_level,
    input logic                     fault,
    input logic                     out_of_range
);

    // a table write answers in the next beat with an all-zero result
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_WRITE) |=>
            done && (diameter_um == '0) && (pwm_level == '0) && !fault && !out_of_range)
        else $error("table write result missing or not zero");

    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_CONVERT) |=> busy && !done)
        else $error("conversion did not enter busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("conversion ended without a result");

endmodule

bind sensor_table_interpolator sti_checker u_sti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .done         (done),
    .diameter_um  (diameter_um),
    .pwm_level    (pwm_level),
    .fault        (fault),
    .out_of_range (out_of_range)
);

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sti_pkg::*;

    typedef struct {
        logic signed [DIAM_W-1:0] dia;
        logic [PWM_W-1:0]         pwm;
        logic                     fault;
        logic                     oor;
    } conv_result_t;

    class diameter_predictor;
        logic [ADC_BITS_DEF-1:0] bp_adc [TABLE_DEPTH_DEF];
        logic [DIA_W-1:0]        bp_dia [TABLE_DEPTH_DEF];
        logic [CNT_CFG_W-1:0]    entry_count = ENTRY_COUNT_RST;
        logic [DIA_W-1:0]        pwm_low     = PWM_LOW_RST;
        logic [DIA_W-1:0]        pwm_high    = PWM_HIGH_RST;
        logic [DIA_W-1:0]        fault_min   = FAULT_MIN_RST;
        logic [SAT_W-1:0]        sat_adc     = SAT_ADC_RST;
        conv_result_t            due_results [$];
        int                      mismatches  = 0;

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ENTRY_COUNT: entry_count = val[CNT_CFG_W-1:0];
                REG_PWM_LOW:     pwm_low     = val[DIA_W-1:0];
                REG_PWM_HIGH:    pwm_high    = val[DIA_W-1:0];
                REG_FAULT_MIN:   fault_min   = val[DIA_W-1:0];
                REG_SAT_ADC:     sat_adc     = val[SAT_W-1:0];
                default: ;
            endcase
        endfunction

        // Called once per accepted beat; queues the result it must produce.
        function void note_request(logic req, logic [ENTRY_IDX_W-1:0] idx,
                                   logic [ADC_BITS_DEF-1:0] ea, logic [DIA_W-1:0] ed,
                                   logic [ADC_BITS_DEF-1:0] sm);
            conv_result_t r;
            longint a0, a1, d0, d1, q, v, p, lo, hi, fm;
            int n;
            int i;
            bit hit;
            r.dia = '0;
            r.pwm = '0;
            r.fault = 1'b0;
            r.oor = 1'b0;
            if (req == REQ_WRITE) begin
                bp_adc[idx] = ea;
                bp_dia[idx] = ed;
            end else begin
                n = int'(entry_count);
                if (n < 2) n = 2;
                if (n > TABLE_DEPTH_DEF) n = TABLE_DEPTH_DEF;
                hit = 1'b0;
                v = longint'(bp_dia[n-1]);
                for (i = 1; i < n && !hit; i++) begin
                    if (bp_adc[i] > sm) begin
                        a0 = longint'(bp_adc[i-1]);
                        a1 = longint'(bp_adc[i]);
                        d0 = longint'(bp_dia[i-1]);
                        d1 = longint'(bp_dia[i]);
                        q = 0;
                        if (a1 != a0)
                            q = ((d1 - d0) * (longint'(sm) - a0)) / (a1 - a0);
                        v = d0 + q;
                        if (v > 32767) v = 32767;
                        if (v < -32768) v = -32768;
                        hit = 1'b1;
                    end
                end
                fm = longint'(fault_min);
                lo = longint'(pwm_low);
                hi = longint'(pwm_high);
                if (hi <= lo) begin
                    p = 0;
                end else begin
                    p = ((v - lo) * 255) / (hi - lo);
                    if (p < 0) p = 0;
                    if (p > 255) p = 255;
                end
                r.dia = v[DIAM_W-1:0];
                r.pwm = p[PWM_W-1:0];
                r.fault = (sm < sat_adc) || (v < fm);
                r.oor = !hit;
            end
            due_results.push_back(r);
        endfunction

        task check_result(logic signed [DIAM_W-1:0] dia, logic [PWM_W-1:0] pwm,
                          logic f, logic o);
            conv_result_t e;
            if (due_results.size() == 0) begin
                report($sformatf("result with nothing pending: dia=%0d pwm=%0d", dia, pwm));
                return;
            end
            e = due_results.pop_front();
            if (dia !== e.dia)
                report($sformatf("diameter_um got %0d want %0d", dia, e.dia));
            if (pwm !== e.pwm)
                report($sformatf("pwm_level got %0d want %0d", pwm, e.pwm));
            if (f !== e.fault)
                report($sformatf("fault got %b want %b", f, e.fault));
            if (o !== e.oor)
                report($sformatf("out_of_range got %b want %b", o, e.oor));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      req_type = 1'b0;
    logic [ENTRY_IDX_W-1:0]    entry_index = '0;
    logic [ADC_BITS_DEF-1:0]   entry_adc = '0;
    logic [DIA_W-1:0]          entry_dia_um = '0;
    logic [ADC_BITS_DEF-1:0]   sample = '0;
    logic                      done;
    logic signed [DIAM_W-1:0]  diameter_um;
    logic [PWM_W-1:0]          pwm_level;
    logic                      fault;
    logic                      out_of_range;

    diameter_predictor sb;
    int  items_sent = 0;
    bit  no_idle = 1'b0;

    sensor_table_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .entry_adc    (entry_adc),
        .entry_dia_um (entry_dia_um),
        .sample       (sample),
        .done         (done),
        .diameter_um  (diameter_um),
        .pwm_level    (pwm_level),
        .fault        (fault),
        .out_of_range (out_of_range)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(diameter_um, pwm_level, fault, out_of_range);
    end

    task automatic issue(input logic req, input logic [ENTRY_IDX_W-1:0] idx,
                         input logic [ADC_BITS_DEF-1:0] ea, input logic [DIA_W-1:0] ed,
                         input logic [ADC_BITS_DEF-1:0] sm);
        int gap;
        start        <= 1'b1;
        req_type     <= req;
        entry_index  <= idx;
        entry_adc    <= ea;
        entry_dia_um <= ed;
        sample       <= sm;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(req, idx, ea, ed, sm);
        items_sent++;
        if (!no_idle && $urandom_range(0, 99) < 36) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 64) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every queued beat has produced its result
    task automatic drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_done();
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // ascending breakpoints, random diameters; zero steps give equal neighbors
    task automatic load_table();
        int a;
        int d;
        bit wide;
        a = $urandom_range(0, 80);
        wide = ($urandom_range(0, 9) < 3);
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            d = wide ? $urandom_range(0, 32767) : $urandom_range(0, 6000);
            issue(REQ_WRITE, ENTRY_IDX_W'(i), ADC_BITS_DEF'(a), DIA_W'(d),
                  ADC_BITS_DEF'($urandom));
            a = a + $urandom_range(0, 70);
            if (a > 1023) a = 1023;
        end
    endtask

    initial
    begin
        int blk;
        int pick;
        int s;
        int w;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] val;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, saturation threshold, out of range
        issue(REQ_WRITE, 4'd0, 10'd0, 15'd0, 10'd1023);
        issue(REQ_WRITE, 4'd1, 10'd1023, 15'd32767, 10'd0);
        issue(REQ_CONVERT, 4'd15, 10'd1023, 15'd32767, 10'd0);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd1023);
        issue(REQ_CONVERT, 4'd7, 10'd512, 15'd16384, 10'd512);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd2);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd3);
        // extrapolation saturating low, then high
        issue(REQ_WRITE, 4'd0, 10'd1000, 15'd0, 10'd0);
        issue(REQ_WRITE, 4'd1, 10'd1001, 15'd32767, 10'd0);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd0);
        issue(REQ_WRITE, 4'd0, 10'd1000, 15'd32767, 10'd0);
        issue(REQ_WRITE, 4'd1, 10'd1001, 15'd0, 10'd0);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd0);
        // equal neighbors
        issue(REQ_WRITE, 4'd0, 10'd500, 15'd1200, 10'd0);
        issue(REQ_WRITE, 4'd1, 10'd500, 15'd2500, 10'd0);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd100);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd500);
        // descending pair
        issue(REQ_WRITE, 4'd0, 10'd900, 15'd4000, 10'd0);
        issue(REQ_WRITE, 4'd1, 10'd100, 15'd1000, 10'd0);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd50);

        // empty pwm span, entry count below range
        drain();
        set_reg(REG_ENTRY_COUNT, 15'd1);
        set_reg(REG_PWM_LOW, 15'd3000);
        set_reg(REG_PWM_HIGH, 15'd3000);
        set_reg(REG_FAULT_MIN, 15'd0);
        set_reg(REG_SAT_ADC, 15'd0);
        cfg_done();
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd50);
        drain();
        set_reg(REG_ENTRY_COUNT, 15'd0);
        set_reg(REG_PWM_LOW, 15'd32767);
        set_reg(REG_PWM_HIGH, 15'd0);
        set_reg(REG_FAULT_MIN, 15'd32767);
        set_reg(REG_SAT_ADC, 15'd1023);
        cfg_done();
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd1023);
        issue(REQ_CONVERT, 4'd0, 10'd0, 15'd0, 10'd0);

        blk = 0;
        while (items_sent < 825) begin
            drain();
            for (int r = 0; r < 5; r++) begin
                if (blk == 0 || $urandom_range(0, 99) < 60) begin
                    reg_idx = CFG_IDX_W'(r);
                    pick = $urandom_range(0, 9);
                    case (reg_idx)
                        REG_ENTRY_COUNT:
                            val = CFG_DATA_W'((pick == 0) ? $urandom_range(0, 1) :
                                              (pick == 1) ? $urandom_range(17, 31) :
                                              (pick < 4)  ? 16 :
                                              (pick == 4) ? 2 : $urandom_range(2, 16));
                        REG_PWM_LOW:
                            val = CFG_DATA_W'((pick < 3) ? 0 : (pick == 3) ? 32767 :
                                              $urandom_range(0, 4000));
                        REG_PWM_HIGH:
                            val = CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 32767 :
                                              $urandom_range(1000, 6000));
                        REG_FAULT_MIN:
                            val = CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 32767 :
                                              $urandom_range(0, 5000));
                        default:
                            val = CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 1023 :
                                              $urandom_range(0, 40));
                    endcase
                    set_reg(reg_idx, val);
                end
            end
            cfg_done();
            no_idle = (blk == 3 || blk == 4);
            if (blk == 0)
                load_table();
            for (int k = 0; k < 60; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    load_table();
                end else if (pick < 14) begin
                    issue(REQ_WRITE, ENTRY_IDX_W'($urandom), ADC_BITS_DEF'($urandom),
                          DIA_W'($urandom), ADC_BITS_DEF'($urandom));
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        s = $urandom_range(0, 1023);
                    end else if (pick < 8) begin
                        s = int'(sb.bp_adc[$urandom_range(0, 15)]) +
                            int'($urandom_range(0, 4)) - 2;
                        if (s < 0) s = 0;
                        if (s > 1023) s = 1023;
                    end else begin
                        s = (pick == 8) ? 0 : 1023;
                    end
                    issue(REQ_CONVERT, ENTRY_IDX_W'($urandom), ADC_BITS_DEF'($urandom),
                          DIA_W'($urandom), ADC_BITS_DEF'(s));
                end
            end
            blk++;
        end

        start <= 1'b0;
        for (w = 0; w < 2000 && sb.due_results.size() != 0; w++)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
        if (sb.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
